[src/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg
// shared types and constants for the progressive refinement scan sequencer
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int unsigned DimW  = 13;
  localparam int unsigned CoordW = 12;
  localparam int unsigned SideW = 9;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_INITIAL_STEP = 2'd2
  } cfg_reg_t;

  localparam logic [DimW-1:0]  FrameWidthRst  = 13'd640;
  localparam logic [DimW-1:0]  FrameHeightRst = 13'd480;
  localparam logic [SideW-1:0] InitStepRst    = 9'd64;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } scan_state_t;

endpackage

[src/progressive_refinement_scan.sv]
// ----------------------------------------------------------------------------
// progressive_refinement_scan
// coarse-to-fine sample sequencer that walks a frame in halving square blocks
// ----------------------------------------------------------------------------
// Each input word is a request: restart=1 begins a new scan at the coarsest
// pass (block side = initial_step) and returns its first sample, restart=0
// returns the next sample. The frame is covered left to right, top to bottom,
// with the last block of every row and column clipped to the frame edge; the
// side halves after each full pass down to 1. From the second pass on, blocks
// whose column and row index within the pass are both even were already
// sampled and are skipped. Every result word carries the sample point (row
// counted from the bottom), the fill rectangle (rows counted from the top)
// and the current side, or done_res=1 with all other fields zero once no
// samples remain. One block, row end or pass change is evaluated per clock by
// a single position/clip unit under a two-state sequencer, while the output
// register has room. A request is accepted, then steps are evaluated until a
// block is emitted or the scan is done; each already sampled block that is
// skipped adds a step. Row and pass changes ride along with the block step;
// a pass with nothing new to sample (tiny frames) or a position left beyond
// a narrowed frame edge adds a step of its own. The block is not ready while a
// request is in work; a finished result sits in the output register while
// the next request is taken. Configuration writes apply to the next
// evaluated block; a new initial_step takes effect at the next restart.
module progressive_refinement_scan #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [prs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [prs_pkg::DimW-1:0]  cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      restart,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [prs_pkg::CoordW-1:0] sample_x,
  output logic [prs_pkg::CoordW-1:0] sample_y,
  output logic [prs_pkg::CoordW-1:0] rect_left,
  output logic [prs_pkg::CoordW-1:0] rect_top,
  output logic [prs_pkg::DimW-1:0]  rect_right,
  output logic [prs_pkg::DimW-1:0]  rect_bottom,
  output logic [prs_pkg::SideW-1:0] block_side,
  output logic                      done_res
);
  import prs_pkg::*;

  // frame dimensions above the cap are treated as the cap
  localparam logic [DimW:0] DimCap =
    (MAX_DIM > 8191) ? 14'd8191 : (DimW+1)'(MAX_DIM);

  // configuration registers
  logic [DimW-1:0]  frame_width;
  logic [DimW-1:0]  frame_height;
  logic [SideW-1:0] initial_step;

  // scan position state
  scan_state_t      state, state_next;
  logic [SideW-1:0] current_side, current_side_next;
  logic [DimW-1:0]  block_left, block_left_next;
  logic [DimW-1:0]  block_top, block_top_next;
  logic             column_odd, column_odd_next;
  logic             row_odd, row_odd_next;
  logic             refining, refining_next;
  logic             finished, finished_next;
  logic             out_valid_next;

  // result payload staging
  logic              load;
  logic [DimW-1:0]   ld_left, ld_top, ld_right, ld_bottom, ld_sy;
  logic [SideW-1:0]  ld_side;
  logic              ld_done;

  // shared position / clip unit
  logic [DimW-1:0] w, h;
  logic [DimW:0]   left_sum, top_sum;
  logic            step_en;

  always_comb begin
    w = ({1'b0, frame_width} > DimCap) ? DimCap[DimW-1:0] : frame_width;
    h = ({1'b0, frame_height} > DimCap) ? DimCap[DimW-1:0] : frame_height;
  end

  assign left_sum = {1'b0, block_left} + {{(DimW+1-SideW){1'b0}}, current_side};
  assign top_sum  = {1'b0, block_top} + {{(DimW+1-SideW){1'b0}}, current_side};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FrameWidthRst;
      frame_height <= FrameHeightRst;
      initial_step <= InitStepRst;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_INITIAL_STEP: initial_step <= cfg_data[SideW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      current_side <= InitStepRst;
      block_left   <= '0;
      block_top    <= '0;
      column_odd   <= 1'b0;
      row_odd      <= 1'b0;
      refining     <= 1'b0;
      finished     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      current_side <= current_side_next;
      block_left   <= block_left_next;
      block_top    <= block_top_next;
      column_odd   <= column_odd_next;
      row_odd      <= row_odd_next;
      refining     <= refining_next;
      finished     <= finished_next;
      out_valid    <= out_valid_next;
    end
  end

  // output register, payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      sample_x    <= ld_left[CoordW-1:0];
      sample_y    <= ld_sy[CoordW-1:0];
      rect_left   <= ld_left[CoordW-1:0];
      rect_top    <= ld_top[CoordW-1:0];
      rect_right  <= ld_right;
      rect_bottom <= ld_bottom;
      block_side  <= ld_side;
      done_res    <= ld_done;
    end
  end

  // sequencer: one scan step per clock while the output register has room
  always_comb begin
    state_next        = state;
    current_side_next = current_side;
    block_left_next   = block_left;
    block_top_next    = block_top;
    column_odd_next   = column_odd;
    row_odd_next      = row_odd;
    refining_next     = refining;
    finished_next     = finished;
    out_valid_next    = out_valid && !out_ready;

    load      = 1'b0;
    ld_left   = block_left;
    ld_top    = block_top;
    ld_right  = (left_sum > {1'b0, w}) ? w : left_sum[DimW-1:0];
    ld_bottom = (top_sum > {1'b0, h}) ? h : top_sum[DimW-1:0];
    ld_sy     = h - block_top - 13'd1;
    ld_side   = current_side;
    ld_done   = 1'b0;

    in_ready = (state == ST_IDLE);
    step_en  = (state == ST_RUN) && (!out_valid || out_ready);

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
          if (restart) begin
            current_side_next = initial_step;
            block_left_next   = '0;
            block_top_next    = '0;
            column_odd_next   = 1'b0;
            row_odd_next      = 1'b0;
            refining_next     = 1'b0;
            finished_next     = 1'b0;
          end
        end
      end
      ST_RUN: begin
        if (step_en) begin
          priority if (finished || current_side == '0 || w == '0 || h == '0) begin
            // nothing left to sample: report done with zero fields
            finished_next  = 1'b1;
            load           = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
            ld_left        = '0;
            ld_top         = '0;
            ld_right       = '0;
            ld_bottom      = '0;
            ld_sy          = '0;
            ld_side        = '0;
            ld_done        = 1'b1;
          end else if (block_top >= h) begin
            // position past the bottom edge: next pass
            block_top_next    = '0;
            row_odd_next      = 1'b0;
            block_left_next   = '0;
            column_odd_next   = 1'b0;
            refining_next     = 1'b1;
            current_side_next = current_side >> 1;
          end else if (block_left >= w) begin
            // position past the right edge: next row
            block_left_next = '0;
            column_odd_next = 1'b0;
            if (top_sum >= {1'b0, h}) begin
              block_top_next    = '0;
              row_odd_next      = 1'b0;
              refining_next     = 1'b1;
              current_side_next = current_side >> 1;
            end else begin
              block_top_next = top_sum[DimW-1:0];
              row_odd_next   = !row_odd;
            end
          end else begin
            // regular block: advance, then emit unless already sampled
            if (left_sum >= {1'b0, w}) begin
              block_left_next = '0;
              column_odd_next = 1'b0;
              if (top_sum >= {1'b0, h}) begin
                block_top_next    = '0;
                row_odd_next      = 1'b0;
                refining_next     = 1'b1;
                current_side_next = current_side >> 1;
              end else begin
                block_top_next = top_sum[DimW-1:0];
                row_odd_next   = !row_odd;
              end
            end else begin
              block_left_next = left_sum[DimW-1:0];
              column_odd_next = !column_odd;
            end
            if (!refining || column_odd || row_odd) begin
              load           = 1'b1;
              out_valid_next = 1'b1;
              state_next     = ST_IDLE;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // a request is never followed directly by another acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in work");

  // done word carries zero fields
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |->
      (sample_x == '0 && rect_right == '0 && rect_bottom == '0 && block_side == '0))
    else $error("done word with nonzero fields");

  // sample rectangle is never empty
  a_rect_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |->
      ({1'b0, rect_left} < rect_right && {1'b0, rect_top} < rect_bottom &&
       block_side != '0))
    else $error("empty fill rectangle");

endmodule
